// ===== src/swdc_pkg.sv =====
// Package for the sliding-window distinct-count block: sizes, link and state types.
`timescale 1ns / 1ps

package swdc_pkg;

   // Deepest window the cell chain holds.
   localparam int WINDOW_MAX = 64;

   // Field widths fixed by the interface.
   localparam int VALUE_W = 32;
   localparam int CFG_W   = 7;
   localparam int OUT_W   = 7;

   // Counter wide enough to hold WINDOW_MAX itself.
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   // Popcount tree: first level sums groups of GROUP_SIZE flags.
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W      = $clog2(GROUP_SIZE + 1);
   localparam int PAD_BITS   = NUM_GROUPS * GROUP_SIZE;

   // Data handed from one cell to the next on every shift.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      first;  // no equal value stands nearer the head
   } link_type;

   // Strobes from the sequencer to the popcount tree.
   typedef struct packed {
      logic load_groups;
   } count_ctrl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_TOTAL
   } state_type;

endpackage

// ===== src/swdc_req_if.sv =====
// Input channel interface: value and start flag with valid/ready.
`timescale 1ns / 1ps

interface swdc_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [swdc_pkg::VALUE_W-1:0]        value;
   logic                                       start_req;

   modport source (output valid, output value, output start_req, input ready);
   modport sink   (input valid, input value, input start_req, output ready);
endinterface

// ===== src/swdc_rsp_if.sv =====
// Result channel interface: distinct count with valid/ready.
`timescale 1ns / 1ps

interface swdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swdc_pkg::OUT_W-1:0]    distinct_count;

   modport source (output valid, output distinct_count, input ready);
   modport sink   (input valid, input distinct_count, output ready);
endinterface

// ===== src/swdc_csr_if.sv =====
// Configuration write channel interface: window size with valid/ready.
`timescale 1ns / 1ps

interface swdc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [swdc_pkg::CFG_W-1:0]    window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

// ===== src/swdc_cell.sv =====
// One window cell: stores a value and its first-occurrence flag, shifts toward the tail.
`timescale 1ns / 1ps

module swdc_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic signed [swdc_pkg::VALUE_W-1:0]  new_value,
   input  swdc_pkg::link_type                   link_in,
   output swdc_pkg::link_type                   link_out,
   output logic                                 first_out
);

   logic signed [swdc_pkg::VALUE_W-1:0] value_ff;
   logic                                first_ff;

   // Shift in the neighbor's value; the flag survives unless the arriving value matches.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= link_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else if (shift_en) begin
         first_ff <= link_in.first;
      end
   end

   // Handed on: this entry stays a first occurrence only if it differs from the new value.
   assign link_out.value = value_ff;
   assign link_out.first = first_ff & (value_ff != new_value);
   assign first_out      = first_ff;

endmodule

// ===== src/swdc_popcount.sv =====
// Two-level popcount of the masked first-occurrence flags.
`timescale 1ns / 1ps

module swdc_popcount (
   input  logic                                clock,
   input  swdc_pkg::count_ctrl_type            ctrl,
   input  logic [swdc_pkg::WINDOW_MAX-1:0]     flags,
   input  logic [swdc_pkg::CNT_W-1:0]          win_len,
   output logic [swdc_pkg::CNT_W-1:0]          total
);

   logic [swdc_pkg::PAD_BITS-1:0]   masked;
   logic [swdc_pkg::GRP_W-1:0]      group_in [swdc_pkg::NUM_GROUPS];
   logic [swdc_pkg::GRP_W-1:0]      group_ff [swdc_pkg::NUM_GROUPS];

   // Keep only the entries inside the current window, pad the last group.
   always_comb begin
      masked = '0;
      for (int i = 0; i < swdc_pkg::WINDOW_MAX; i++) begin
         masked[i] = flags[i] & (swdc_pkg::CNT_W'(i) < win_len);
      end
   end

   // First level: one count per group of flags.
   always_comb begin
      for (int g = 0; g < swdc_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < swdc_pkg::GROUP_SIZE; b++) begin
            group_in[g] = group_in[g]
                        + swdc_pkg::GRP_W'(masked[g * swdc_pkg::GROUP_SIZE + b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_groups) begin
         group_ff <= group_in;
      end
   end

   // Second level: sum of the registered group counts.
   always_comb begin
      total = '0;
      for (int g = 0; g < swdc_pkg::NUM_GROUPS; g++) begin
         total = total + swdc_pkg::CNT_W'(group_ff[g]);
      end
   end

endmodule

// ===== src/sliding_window_distinct_count.sv =====
// Top level: cell chain holding the window, popcount tree and result sequencer.
//
//   channel  dir   payload                      transfer when
//   req      in    value[31:0], start_req       req_bus.valid & req_bus.ready
//   rsp      out   distinct_count[6:0]          rsp_bus.valid & rsp_bus.ready
//   csr      in    window_size[6:0]             csr_bus.valid & csr_bus.ready
//
// An item that yields no result leaves the sequencer idle, ready for the next item;
// one that yields a result passes cell shift, group count and total (the states of
// the two-level popcount) before the next item is taken. The result register frees the
// input side while a result waits; a stalled result holds the block in the total state.
// Reset (synchronous) clears fill count, flags, window size to 1 and the sequencer.
// Window entries themselves are not reset; req and csr are not ready during reset.
`timescale 1ns / 1ps

module sliding_window_distinct_count (
   input  logic          clock,
   input  logic          reset,
   swdc_req_if.sink      req_bus,
   swdc_rsp_if.source    rsp_bus,
   swdc_csr_if.sink      csr_bus
);

   swdc_pkg::state_type               state_ff, state_in;
   logic [swdc_pkg::CFG_W-1:0]        window_size_ff;
   logic [swdc_pkg::CNT_W-1:0]        fill_count_ff, fill_count_in;
   logic [swdc_pkg::CNT_W-1:0]        fill_base;
   logic [swdc_pkg::CNT_W-1:0]        win_len;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swdc_pkg::OUT_W-1:0]        rsp_count_ff;
   logic                              req_xfer;
   logic                              emit;
   logic                              rsp_free;
   logic                              load_rsp;
   swdc_pkg::count_ctrl_type          count_ctrl;
   swdc_pkg::link_type                links [swdc_pkg::WINDOW_MAX + 1];
   logic [swdc_pkg::WINDOW_MAX-1:0]   flags;
   logic [swdc_pkg::CNT_W-1:0]        total;

   // Configuration register.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swdc_pkg::CFG_W'(1);
      end else if (csr_bus.valid && csr_bus.ready) begin
         window_size_ff <= csr_bus.window_size;
      end
   end

   // Effective window length: zero counts as one, large values saturate.
   always_comb begin
      if (window_size_ff == '0) begin
         win_len = swdc_pkg::CNT_W'(1);
      end else if (32'(window_size_ff) > swdc_pkg::WINDOW_MAX) begin
         win_len = swdc_pkg::CNT_W'(swdc_pkg::WINDOW_MAX);
      end else begin
         win_len = swdc_pkg::CNT_W'(window_size_ff);
      end
   end

   assign req_xfer = req_bus.valid && req_bus.ready;

   // Fill count: restart on start_req, saturate at the chain depth.
   always_comb begin
      fill_base = req_bus.start_req ? '0 : fill_count_ff;
      if (32'(fill_base) < swdc_pkg::WINDOW_MAX) begin
         fill_count_in = fill_base + swdc_pkg::CNT_W'(1);
      end else begin
         fill_count_in = fill_base;
      end
   end

   assign emit = (fill_count_in >= win_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (req_xfer) begin
         fill_count_ff <= fill_count_in;
      end
   end

   // Cell chain: the head link carries the arriving value as a first occurrence.
   assign links[0].value = req_bus.value;
   assign links[0].first = 1'b1;

   for (genvar k = 0; k < swdc_pkg::WINDOW_MAX; k++) begin : g_cell
      swdc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (req_xfer),
         .new_value (req_bus.value),
         .link_in   (links[k]),
         .link_out  (links[k + 1]),
         .first_out (flags[k])
      );
   end

   // Popcount of the first occurrences inside the window.
   swdc_popcount u_popcount (
      .clock   (clock),
      .ctrl    (count_ctrl),
      .flags   (flags),
      .win_len (win_len),
      .total   (total)
   );

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swdc_pkg::ST_IDLE: begin
            if (req_xfer && emit) begin
               state_in = swdc_pkg::ST_GROUP;
            end
         end
         swdc_pkg::ST_GROUP: begin
            state_in = swdc_pkg::ST_TOTAL;
         end
         swdc_pkg::ST_TOTAL: begin
            if (rsp_free) begin
               state_in = swdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swdc_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_bus.ready          = 1'b0;
      count_ctrl.load_groups = 1'b0;
      load_rsp               = 1'b0;
      unique case (state_ff)
         swdc_pkg::ST_IDLE: begin
            req_bus.ready = !reset;
         end
         swdc_pkg::ST_GROUP: begin
            count_ctrl.load_groups = 1'b1;
         end
         swdc_pkg::ST_TOTAL: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff <= swdc_pkg::OUT_W'(total);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.distinct_count = rsp_count_ff;

endmodule

// ===== test/sliding_window_distinct_count_tb.sv =====
// Testbench for the sliding-window distinct-count block: random and directed streams.
`timescale 1ns / 1ps

module sliding_window_distinct_count_tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [swdc_pkg::VALUE_W-1:0] value;
      logic                         start_req;
   } stream_item_type;

   logic clock = 1'b0;
   logic reset;

   swdc_req_if req_bus ();
   swdc_rsp_if rsp_bus ();
   swdc_csr_if csr_bus ();

   sliding_window_distinct_count dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Items waiting to be offered, and counts expected back
   stream_item_type              send_q[$];
   logic [swdc_pkg::OUT_W-1:0]   count_expect_q[$];

   // Window model
   logic [swdc_pkg::VALUE_W-1:0] window_q [swdc_pkg::WINDOW_MAX] = '{default: '0};
   int                           fill_level = 0;
   logic [swdc_pkg::CFG_W-1:0]   size_reg = swdc_pkg::CFG_W'(1);

   int  error_count = 0;
   int  cycle_count = 0;
   bit  req_done = 1'b0;   // req transfer at the last rising edge
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  stall_armed;
   bit  stall_done = 1'b0;
   int  stall_left = 0;

   always #5 clock = ~clock;

   function automatic int clamp_size(input logic [swdc_pkg::CFG_W-1:0] s);
      if (s == '0) return 1;
      if (s > swdc_pkg::WINDOW_MAX) return swdc_pkg::WINDOW_MAX;
      return int'(s);
   endfunction

   // Distinct values among the newest n window entries
   function automatic logic [swdc_pkg::OUT_W-1:0] count_unique(input int n);
      int  total;
      bit  seen;
      total = 0;
      for (int i = 0; i < n; i++) begin
         seen = 1'b0;
         for (int j = 0; j < i; j++) begin
            if (window_q[j] == window_q[i]) seen = 1'b1;
         end
         if (!seen) total++;
      end
      return swdc_pkg::OUT_W'(total);
   endfunction

   // Shift one value into the model and queue a count if the window is full
   task automatic predict_window(input logic [swdc_pkg::VALUE_W-1:0] v, input logic first);
      int eff;
      eff = clamp_size(size_reg);
      if (first) fill_level = 0;
      for (int k = swdc_pkg::WINDOW_MAX - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = v;
      if (fill_level < swdc_pkg::WINDOW_MAX) fill_level++;
      if (fill_level >= eff) count_expect_q = {count_expect_q, count_unique(eff)};
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic push_item(input logic [swdc_pkg::VALUE_W-1:0] v, input logic s);
      stream_item_type it;
      it.value     = v;
      it.start_req = s;
      send_q = {send_q, it};
   endtask

   // Wait until every item is sent and every count is back, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      while (send_q.size() > 0 || req_bus.valid || count_expect_q.size() > 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_window(input logic [swdc_pkg::CFG_W-1:0] s);
      @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.window_size <= s;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Monitor: predict on req transfers, check on rsp transfers, track csr writes
   always @(posedge clock) begin
      req_done = 1'b0;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) size_reg = csr_bus.window_size;
         if (req_bus.valid && req_bus.ready) begin
            req_done = 1'b1;
            predict_window(req_bus.value, req_bus.start_req);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (count_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected count %0d", rsp_bus.distinct_count));
            end else begin
               if (rsp_bus.distinct_count !== count_expect_q[0])
                  report_mismatch($sformatf("distinct_count %0d, expected %0d",
                                            rsp_bus.distinct_count, count_expect_q[0]));
               void'(count_expect_q.pop_front());
            end
         end
      end
   end

   // Driver: next item after each transfer, random gaps between items
   always @(negedge clock) begin
      stream_item_type it;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.value     <= '0;
         req_bus.start_req <= 1'b0;
      end else if (!req_bus.valid || req_done) begin
         if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = send_q.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.value     <= it.value;
            req_bus.start_req <= it.start_req;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_armed && !stall_done) begin
         stall_done = 1'b1;
         stall_left = 400;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      logic [swdc_pkg::CFG_W-1:0]   size_sel;
      logic [swdc_pkg::VALUE_W-1:0] pool [8];
      logic [swdc_pkg::VALUE_W-1:0] v;
      int                           eff;
      int                           quota;
      int                           sent;
      int                           seq_len;
      int                           pool_n;
      bit                           use_pool;
      bit                           carry_on;
      logic                         s;

      reset               = 1'b1;
      csr_bus.valid       = 1'b0;
      csr_bus.window_size = '0;
      send_idle_pct       = 16;
      recv_idle_pct       = 16;
      stall_armed         = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Window of one: value extremes, each yields a count of one
      write_window(swdc_pkg::CFG_W'(1));
      push_item(32'h8000_0000, 1'b1);
      push_item(32'h7FFF_FFFF, 1'b0);
      push_item(32'h0000_0000, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b0);
      push_item(32'h5555_5555, 1'b0);
      push_item(32'hAAAA_AAAA, 1'b0);
      wait_drained();

      // Size zero acts as one
      write_window(swdc_pkg::CFG_W'(0));
      push_item(32'd5, 1'b1);
      push_item(32'd5, 1'b0);
      wait_drained();

      // Window of three, repeats, then short sequences cut by start
      write_window(swdc_pkg::CFG_W'(3));
      push_item(32'd1, 1'b1);
      push_item(32'd1, 1'b0);
      push_item(32'd2, 1'b0);
      push_item(32'd2, 1'b0);
      push_item(32'd3, 1'b0);
      push_item(32'd1, 1'b0);
      push_item(32'd7, 1'b1);
      push_item(32'd7, 1'b0);
      push_item(32'd9, 1'b1);
      push_item(32'd9, 1'b0);
      push_item(32'd9, 1'b0);
      wait_drained();

      // Shrink mid-sequence: takes effect on the running fill count
      write_window(swdc_pkg::CFG_W'(2));
      push_item(32'hFFFF_FFFF, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b0);

      // Random phases, each with its own window size
      for (int p = 0; p < 24; p++) begin
         case (p)
            0: size_sel = swdc_pkg::CFG_W'(127);
            1: size_sel = swdc_pkg::CFG_W'(64);
            2: size_sel = swdc_pkg::CFG_W'(65);
            3: size_sel = swdc_pkg::CFG_W'(0);
            4: size_sel = swdc_pkg::CFG_W'(63);
            5: size_sel = swdc_pkg::CFG_W'(2);
            8: size_sel = swdc_pkg::CFG_W'(1);
            default: begin
               if ($urandom_range(3) == 0)
                  size_sel = swdc_pkg::CFG_W'($urandom_range(64, 13));
               else
                  size_sel = swdc_pkg::CFG_W'($urandom_range(12, 1));
            end
         endcase
         wait_drained();
         write_window(size_sel);
         eff = clamp_size(size_sel);
         quota = 20 + eff;
         send_idle_pct = 16;
         recv_idle_pct = 16;
         if (p == 8) begin
            // long receiver hold-off while the sender keeps offering
            stall_armed   = 1'b1;
            send_idle_pct = 0;
            quota         = 200;
         end else if (p == 12) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // With even odds a phase carries the old sequence across the size change
         carry_on = ($urandom_range(1) == 0);
         sent = 0;
         while (sent < quota) begin
            if ($urandom_range(4) != 0) seq_len = eff + $urandom_range(eff + 8, 0);
            else seq_len = $urandom_range(eff, 1);
            use_pool = ($urandom_range(3) != 0);
            pool_n   = $urandom_range(6, 1);
            for (int i = 0; i < pool_n; i++) begin
               case ($urandom_range(7))
                  0: pool[i] = 32'h8000_0000;
                  1: pool[i] = 32'h7FFF_FFFF;
                  2: pool[i] = 32'h0000_0000;
                  3: pool[i] = 32'hFFFF_FFFF;
                  default: pool[i] = $urandom;
               endcase
            end
            for (int i = 0; i < seq_len; i++) begin
               v = use_pool ? pool[$urandom_range(pool_n - 1)] : $urandom;
               s = (i == 0 && !carry_on) || ($urandom_range(49) == 0);
               push_item(v, s);
               sent++;
            end
            carry_on = 1'b0;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && count_expect_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/swdc_pkg.sv
src/swdc_req_if.sv
src/swdc_rsp_if.sv
src/swdc_csr_if.sv
src/swdc_cell.sv
src/swdc_popcount.sv
src/sliding_window_distinct_count.sv
test/sliding_window_distinct_count_tb.sv
